>>> rtl/core/bli2c_pkg.sv
// shared types and constants of the bit level i2c master
package bli2c_pkg;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_SEND  = 3'd2,
    MODE_WACK  = 3'd3,
    MODE_RECV  = 3'd4,
    MODE_ACK   = 3'd5,
    MODE_NACK  = 3'd6
  } mode_e;

  localparam logic [2:0] ModeInvalid = 3'd7;
  localparam logic [7:0] PhaseTicksReset = 8'd50;
  localparam int unsigned InWidth = 16;
  localparam int unsigned OutWidth = 16;

  typedef struct packed {
    logic       cmd_ok;
    mode_e      mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t tick;
  } deq_t;

endpackage

>>> rtl/core/bli2c_front.sv
// front end: accepts ticks, classifies the command and queues them
module bli2c_front
  import bli2c_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // cmd_valid, mode[2:0], tx_byte[7:0], sda_in, zero fill
  input  logic [InWidth-1:0] s_axis_tdata,
  output deq_t               deq_o,
  input  logic               pop_i
);

  tick_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  tick_t      tick_in;
  logic       push;
  logic       pop;

  always_comb begin
    tick_in.cmd_ok  = s_axis_tdata[0] && (s_axis_tdata[3:1] != ModeInvalid);
    tick_in.mode    = tick_in.cmd_ok ? mode_e'(s_axis_tdata[3:1]) : MODE_START;
    tick_in.tx_byte = s_axis_tdata[11:4];
    tick_in.sda_in  = s_axis_tdata[12];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop = pop_i && (count_q != 2'd0);

  assign deq_o.valid = (count_q != 2'd0);
  assign deq_o.tick = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= tick_in;
    end
  end

endmodule

>>> rtl/core/bli2c_back.sv
// back end: line phase sequencer with registered result
module bli2c_back
  import bli2c_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  deq_t                deq_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_out, sda_out, busy_res, done_res, rx_byte[7:0], no_ack, zero fill
  output logic [OutWidth-1:0] m_axis_tdata
);

  logic [7:0] pt_q;
  logic       out_valid_q;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  mode_e      mode_q, mode_d;
  logic       active_q, active_d;
  logic [4:0] phase_q, phase_d;
  logic [1:0] sub_q, sub_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] shift_q, shift_d;
  logic       nack_q, nack_d;
  logic [7:0] rx_q, rx_d;
  logic       done_q, done_d;
  logic [7:0] hold;
  logic       step;

  function automatic logic [4:0] phase_total(mode_e m);
    unique case (m)
      MODE_SEND: phase_total = 5'd24;
      MODE_WACK: phase_total = 5'd3;
      MODE_RECV: phase_total = 5'd16;
      default:   phase_total = 5'd4;
    endcase
  endfunction

  assign cfg_ready_o = 1'b1;
  assign hold = (pt_q == 8'd0) ? 8'd1 : pt_q;
  assign step = deq_i.valid && (!out_valid_q || m_axis_tready);
  assign pop_o = step;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {3'b000, nack_q, rx_q, done_q, active_q, sda_q, scl_q};

  always_comb begin
    logic       apply;
    logic [7:0] tick_n;
    tick_t      t;
    t = deq_i.tick;
    apply = 1'b0;
    tick_n = tick_q + 8'd1;
    scl_d = scl_q;
    sda_d = sda_q;
    mode_d = mode_q;
    active_d = active_q;
    phase_d = phase_q;
    sub_d = sub_q;
    tick_d = tick_q;
    shift_d = shift_q;
    nack_d = nack_q;
    rx_d = rx_q;
    done_d = 1'b0;

    if (active_q) begin
      if (tick_n >= hold) begin
        tick_d = 8'd0;
        if (mode_q == MODE_RECV && phase_q[0]) begin
          shift_d = {shift_q[6:0], t.sda_in};
        end
        if (mode_q == MODE_WACK && phase_q == 5'd2) begin
          nack_d = t.sda_in;
        end
        phase_d = phase_q + 5'd1;
        sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
        if (phase_d >= phase_total(mode_q)) begin
          if (mode_q == MODE_WACK) begin
            scl_d = 1'b0;
          end
          if (mode_q == MODE_RECV) begin
            rx_d = shift_d;
          end
          active_d = 1'b0;
          phase_d = 5'd0;
          done_d = 1'b1;
        end else begin
          apply = 1'b1;
        end
      end else begin
        tick_d = tick_n;
      end
    end else if (t.cmd_ok) begin
      active_d = 1'b1;
      mode_d = t.mode;
      phase_d = 5'd0;
      sub_d = 2'd0;
      tick_d = 8'd0;
      if (t.mode == MODE_SEND) begin
        shift_d = t.tx_byte;
      end
      if (t.mode == MODE_RECV) begin
        shift_d = 8'd0;
        sda_d = 1'b1;
      end
      apply = 1'b1;
    end

    if (apply) begin
      unique case (mode_d)
        MODE_START: begin
          if (phase_d == 5'd0) sda_d = 1'b1;
          else if (phase_d == 5'd1) scl_d = 1'b1;
          else if (phase_d == 5'd2) sda_d = 1'b0;
          else scl_d = 1'b0;
        end
        MODE_STOP: begin
          if (phase_d == 5'd0) scl_d = 1'b0;
          else if (phase_d == 5'd1) sda_d = 1'b0;
          else if (phase_d == 5'd2) scl_d = 1'b1;
          else sda_d = 1'b1;
        end
        MODE_SEND: begin
          if (sub_d == 2'd0) begin
            scl_d = 1'b0;
          end else if (sub_d == 2'd1) begin
            sda_d = shift_d[7];
            shift_d = {shift_d[6:0], 1'b0};
          end else begin
            scl_d = 1'b1;
          end
        end
        MODE_WACK: begin
          if (phase_d == 5'd0) scl_d = 1'b0;
          else if (phase_d == 5'd1) sda_d = 1'b1;
          else scl_d = 1'b1;
        end
        MODE_RECV: scl_d = phase_d[0];
        MODE_ACK, MODE_NACK: begin
          if (phase_d == 5'd0) scl_d = 1'b0;
          else if (phase_d == 5'd1) sda_d = (mode_d == MODE_NACK);
          else if (phase_d == 5'd2) scl_d = 1'b1;
          else scl_d = 1'b0;
        end
        default: scl_d = scl_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= PhaseTicksReset;
      out_valid_q <= 1'b0;
      scl_q <= 1'b1;
      sda_q <= 1'b1;
      mode_q <= MODE_START;
      active_q <= 1'b0;
      phase_q <= 5'd0;
      sub_q <= 2'd0;
      tick_q <= 8'd0;
      shift_q <= 8'd0;
      nack_q <= 1'b0;
      rx_q <= 8'd0;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pt_q <= cfg_data_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
        scl_q <= scl_d;
        sda_q <= sda_d;
        mode_q <= mode_d;
        active_q <= active_d;
        phase_q <= phase_d;
        sub_q <= sub_d;
        tick_q <= tick_d;
        shift_q <= shift_d;
        nack_q <= nack_d;
        rx_q <= rx_d;
        done_q <= done_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !active_q)
    else $error("done while still busy");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (phase_q < phase_total(mode_q)))
    else $error("phase beyond end of command");

  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !active_q && !deq_i.tick.cmd_ok) |=> !active_q)
    else $error("idle block started without a command");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("bit sub-phase out of range");

endmodule

>>> rtl/core/bit_level_i2c_master_core.sv
// top level of the bit level i2c master
// with no stall, a tick is stored in the queue and its result is then registered by the sequencer step
// throughput: one tick per cycle while the result output is not stalled, set by the phase sequencer step
// a two-entry tick queue decouples input acceptance from result stalls
// reset: asynchronous active low; lines released, idle, phase_ticks 50
module bit_level_i2c_master_core
  import bli2c_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd_valid, mode[2:0], tx_byte[7:0], sda_in, zero fill
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_out, sda_out, busy_res, done_res, rx_byte[7:0], no_ack, zero fill
  output logic [OutWidth-1:0] m_axis_tdata
);

  deq_t deq;
  logic pop;

  bli2c_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .deq_o         (deq),
    .pop_i         (pop)
  );

  bli2c_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .deq_i         (deq),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> verif/bit_level_i2c_master_core_tb.sv
// self-checking testbench of the bit level i2c master core
`timescale 1ns / 100ps

module bit_level_i2c_master_core_tb;
  import bli2c_pkg::*;

  typedef struct packed {
    logic       no_ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } line_res_t;

  typedef struct {
    bit         wr;
    logic [7:0] pt;
    logic       cv;
    logic [2:0] md;
    logic [7:0] tx;
    logic       sda;
    bit         hammer;
    bit         typed;
    line_res_t  exp;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i = 8'd0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // cmd_valid, mode[2:0], tx_byte[7:0], sda_in, zero fill
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // scl_out, sda_out, busy_res, done_res, rx_byte[7:0], no_ack, zero fill
  logic [OutWidth-1:0] m_axis_tdata;

  // predictor state
  logic       scl_q, sda_q, act_q, nack_q;
  mode_e      act_mode;
  logic [4:0] ph_idx;
  logic [7:0] tick_cnt, shreg, rx_hold, hold_cfg;

  line_res_t   line_q[$];
  dir_row_t    dir_tab[$];
  int unsigned err_cnt = 0;
  int unsigned ticks_sent = 0;
  int unsigned burst_left = 0;
  logic [7:0]  sink_cyc = 8'd0;
  logic [1:0]  sink_style = 2'd0;
  line_res_t   got_res, want_res;

  bit_level_i2c_master_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned phase_count(mode_e m);
    case (m)
      MODE_SEND: return 24;
      MODE_WACK: return 3;
      MODE_RECV: return 16;
      default:   return 4;
    endcase
  endfunction

  task automatic drive_phase();
    case (act_mode)
      MODE_START: begin
        if (ph_idx == 0) sda_q = 1'b1;
        else if (ph_idx == 1) scl_q = 1'b1;
        else if (ph_idx == 2) sda_q = 1'b0;
        else scl_q = 1'b0;
      end
      MODE_STOP: begin
        if (ph_idx == 0) scl_q = 1'b0;
        else if (ph_idx == 1) sda_q = 1'b0;
        else if (ph_idx == 2) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      MODE_SEND: begin
        if (ph_idx % 3 == 0) scl_q = 1'b0;
        else if (ph_idx % 3 == 1) begin
          sda_q = shreg[7];
          shreg = {shreg[6:0], 1'b0};
        end else scl_q = 1'b1;
      end
      MODE_WACK: begin
        if (ph_idx == 0) scl_q = 1'b0;
        else if (ph_idx == 1) sda_q = 1'b1;
        else scl_q = 1'b1;
      end
      MODE_RECV: scl_q = ph_idx[0];
      default: begin
        if (ph_idx == 0) scl_q = 1'b0;
        else if (ph_idx == 1) sda_q = (act_mode == MODE_NACK);
        else if (ph_idx == 2) scl_q = 1'b1;
        else scl_q = 1'b0;
      end
    endcase
  endtask

  // one tick of the line sequencer
  task automatic advance_sequencer(input logic cv, input logic [2:0] md, input logic [7:0] tx,
                                   input logic sda, output line_res_t r);
    logic [7:0] hold;
    logic       fin;
    hold = (hold_cfg == 8'd0) ? 8'd1 : hold_cfg;
    fin  = 1'b0;
    if (act_q) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= hold) begin
        tick_cnt = 8'd0;
        if (act_mode == MODE_RECV && ph_idx[0]) shreg = {shreg[6:0], sda};
        if (act_mode == MODE_WACK && ph_idx == 2) nack_q = sda;
        ph_idx = ph_idx + 5'd1;
        if (ph_idx >= phase_count(act_mode)) begin
          if (act_mode == MODE_WACK) scl_q = 1'b0;
          if (act_mode == MODE_RECV) rx_hold = shreg;
          act_q  = 1'b0;
          ph_idx = 5'd0;
          fin    = 1'b1;
        end else begin
          drive_phase();
        end
      end
    end else if (cv && md != ModeInvalid) begin
      act_q    = 1'b1;
      act_mode = mode_e'(md);
      ph_idx   = 5'd0;
      tick_cnt = 8'd0;
      if (act_mode == MODE_SEND) shreg = tx;
      if (act_mode == MODE_RECV) begin
        shreg = 8'd0;
        sda_q = 1'b1;
      end
      drive_phase();
    end
    r = '{no_ack: nack_q, rx: rx_hold, done: fin, busy: act_q, sda: sda_q, scl: scl_q};
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    err_cnt++;
  endtask

  task automatic send_tick(input logic cv, input logic [2:0] md, input logic [7:0] tx,
                           input logic sda);
    int unsigned gap;
    line_res_t   r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, sda, tx, md, cv};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_sequencer(cv, md, tx, sda, r);
    line_q.push_back(r);
    ticks_sent++;
  endtask

  // keep ticking until the command in progress has finished
  task automatic drain_busy(input int unsigned noise_pct, input bit sda_rand,
                            input logic sda_fix);
    while (act_q) begin
      send_tick($urandom_range(0, 99) < noise_pct, 3'($urandom_range(0, 7)),
                8'($urandom), sda_rand ? 1'($urandom_range(0, 1)) : sda_fix);
    end
  endtask

  task automatic issue(input logic [2:0] md, input logic [7:0] tx);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3))
        send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
    end
    send_tick(1'b1, md, tx, 1'($urandom_range(0, 1)));
    drain_busy(10, 1'b1, 1'b0);
  endtask

  task automatic i2c_transaction(input int unsigned max_bytes);
    int unsigned n;
    bit          rd;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: issue(3'($urandom_range(0, 7)), 8'($urandom));
        1: repeat ($urandom_range(1, 5))
             send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
        default: begin
          issue(MODE_START, 8'($urandom));
          issue(MODE_SEND, 8'($urandom));
          issue(MODE_STOP, 8'($urandom));
        end
      endcase
    end else begin
      rd = 1'($urandom_range(0, 1));
      n  = (max_bytes == 0) ? 0 : $urandom_range(1, max_bytes);
      issue(MODE_START, 8'($urandom));
      issue(MODE_SEND, {7'($urandom), rd});
      issue(MODE_WACK, 8'($urandom));
      for (int unsigned i = 0; i < n; i++) begin
        if (rd) begin
          issue(MODE_RECV, 8'($urandom));
          issue((i == n - 1) ? MODE_NACK : MODE_ACK, 8'($urandom));
        end else begin
          issue(MODE_SEND, 8'($urandom));
          issue(MODE_WACK, 8'($urandom));
        end
      end
      // sometimes leave the bus open for a repeated start
      if ($urandom_range(0, 3) != 0) issue(MODE_STOP, 8'($urandom));
    end
  endtask

  task automatic run_traffic(input int unsigned budget, input int unsigned max_bytes);
    int unsigned first;
    first = ticks_sent;
    do i2c_transaction(max_bytes); while (ticks_sent - first < budget);
  endtask

  task automatic set_phase_ticks(input logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hold_cfg = v;
  endtask

  task automatic add_row(input bit wr, input logic [7:0] pt, input logic cv,
                         input logic [2:0] md, input logic [7:0] tx, input logic sda,
                         input bit hammer, input bit typed, input line_res_t exp);
    dir_row_t row;
    row = '{wr: wr, pt: pt, cv: cv, md: md, tx: tx, sda: sda,
            hammer: hammer, typed: typed, exp: exp};
    dir_tab.push_back(row);
  endtask

  always @(posedge clk_i) begin
    sink_cyc <= sink_cyc + 8'd1;
    if (sink_cyc == 8'hff) sink_style <= 2'($urandom_range(0, 3));
    case (sink_style)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (sink_cyc[1:0] == 2'd0);
      default: m_axis_tready <= (sink_cyc[3:0] >= 4'd10);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = line_res_t'(m_axis_tdata[12:0]);
      if (line_q.size() == 0) begin
        report_mismatch("transfer with no tick pending", 0, got_res);
      end else begin
        want_res = line_q.pop_front();
        if (got_res.scl !== want_res.scl) report_mismatch("scl", want_res.scl, got_res.scl);
        if (got_res.sda !== want_res.sda) report_mismatch("sda", want_res.sda, got_res.sda);
        if (got_res.busy !== want_res.busy) report_mismatch("busy", want_res.busy, got_res.busy);
        if (got_res.done !== want_res.done) report_mismatch("done", want_res.done, got_res.done);
        if (got_res.rx !== want_res.rx) report_mismatch("rx_byte", want_res.rx, got_res.rx);
        if (got_res.no_ack !== want_res.no_ack)
          report_mismatch("no_ack", want_res.no_ack, got_res.no_ack);
      end
    end
  end

  initial begin
    scl_q    = 1'b1;
    sda_q    = 1'b1;
    act_q    = 1'b0;
    nack_q   = 1'b0;
    act_mode = MODE_START;
    ph_idx   = 5'd0;
    tick_cnt = 8'd0;
    shreg    = 8'd0;
    rx_hold  = 8'd0;
    hold_cfg = PhaseTicksReset;

    // expected: no_ack, rx, done, busy, sda, scl
    add_row(0, 8'd0, 0, MODE_START, 8'h00, 1, 0, 1, {1'b0, 8'h00, 4'b0011});
    add_row(0, 8'd0, 1, ModeInvalid, 8'hff, 1, 0, 1, {1'b0, 8'h00, 4'b0011});
    add_row(0, 8'd0, 1, MODE_START, 8'ha5, 0, 1, 1, {1'b0, 8'h00, 4'b0111});
    add_row(1, 8'd0, 1, MODE_SEND, 8'hff, 1, 0, 1, {1'b0, 8'h00, 4'b0100});
    add_row(0, 8'd0, 1, MODE_WACK, 8'h00, 1, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_SEND, 8'h00, 0, 1, 0, '0);
    add_row(0, 8'd0, 1, MODE_WACK, 8'hff, 0, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_SEND, 8'ha5, 1, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_WACK, 8'h5a, 0, 1, 0, '0);
    add_row(0, 8'd0, 1, MODE_RECV, 8'h00, 1, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_ACK, 8'hff, 1, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_RECV, 8'hff, 0, 1, 0, '0);
    add_row(0, 8'd0, 1, MODE_NACK, 8'h00, 0, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_STOP, 8'hff, 0, 0, 0, '0);
    add_row(1, 8'd1, 1, MODE_START, 8'h00, 1, 1, 0, '0);
    add_row(0, 8'd0, 1, MODE_SEND, 8'h5a, 0, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_WACK, 8'h00, 1, 1, 0, '0);
    add_row(0, 8'd0, 1, MODE_RECV, 8'h00, 1, 0, 0, '0);
    add_row(0, 8'd0, 1, ModeInvalid, 8'h00, 0, 0, 0, '0);
    add_row(0, 8'd0, 1, MODE_NACK, 8'hff, 1, 0, 0, '0);
    add_row(1, 8'd2, 1, MODE_STOP, 8'h00, 0, 1, 0, '0);
    add_row(0, 8'd0, 0, MODE_STOP, 8'hff, 0, 0, 0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) set_phase_ticks(dir_tab[i].pt);
      send_tick(dir_tab[i].cv, dir_tab[i].md, dir_tab[i].tx, dir_tab[i].sda);
      if (dir_tab[i].typed) line_q[$] = dir_tab[i].exp;
      drain_busy(dir_tab[i].hammer ? 100 : 0, 1'b0, dir_tab[i].sda);
    end

    set_phase_ticks(8'd1);
    run_traffic(200, 3);
    set_phase_ticks(8'd0);
    run_traffic(200, 2);
    set_phase_ticks(8'd2);
    run_traffic(250, 3);
    set_phase_ticks(8'd3);
    run_traffic(150, 2);
    set_phase_ticks(8'($urandom_range(4, 12)));
    run_traffic(1, 0);
    // longest hold: one phase change of a start, then the run ends mid-command
    set_phase_ticks(8'd255);
    send_tick(1'b1, MODE_START, 8'($urandom), 1'b1);
    repeat (300)
      send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
                1'($urandom_range(0, 1)));

    s_axis_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> bit_level_i2c_master_core.f
rtl/core/bli2c_pkg.sv
rtl/core/bli2c_front.sv
rtl/core/bli2c_back.sv
rtl/core/bit_level_i2c_master_core.sv
verif/bit_level_i2c_master_core_tb.sv
